>>> rtl/core/dcci_pkg.sv
// Shared types, constants and codes for the day cycle color interpolator.
package dcci_pkg;

  localparam int HOUR_W    = 16;
  localparam int BOUND_W   = 18;
  localparam int COLOR_W   = 32;
  localparam int PHASE_W   = 3;
  localparam int CALC_W    = 20;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int REG_IDX_W = 3;

  localparam int CHANNELS_DEF     = 4;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int MID_DEPTH_DEF    = 4;
  localparam int OUT_DEPTH_DEF    = 2;

  localparam logic signed [BOUND_W-1:0] SUNRISE_BEGIN_RST = 18'sd10240;
  localparam logic signed [BOUND_W-1:0] SUNRISE_END_RST   = 18'sd16384;
  localparam logic signed [BOUND_W-1:0] SUNSET_BEGIN_RST  = 18'sd36864;
  localparam logic signed [BOUND_W-1:0] SUNSET_END_RST    = 18'sd43008;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SUNRISE_BEGIN = 3'd0,
    REG_SUNRISE_END   = 3'd1,
    REG_SUNSET_BEGIN  = 3'd2,
    REG_SUNSET_END    = 3'd3,
    REG_NIGHT_COLOR   = 3'd4,
    REG_SUNRISE_COLOR = 3'd5,
    REG_DAY_COLOR     = 3'd6,
    REG_SUNSET_COLOR  = 3'd7
  } reg_idx_t;

  typedef enum logic [PHASE_W-1:0] {
    PHASE_NIGHT   = 3'd0,
    PHASE_SUNRISE = 3'd1,
    PHASE_DAY     = 3'd2,
    PHASE_SUNSET  = 3'd3,
    PHASE_NONE    = 3'd4
  } phase_t;

  typedef struct packed {
    logic signed [BOUND_W-1:0] sunrise_begin;
    logic signed [BOUND_W-1:0] sunrise_end;
    logic signed [BOUND_W-1:0] sunset_begin;
    logic signed [BOUND_W-1:0] sunset_end;
    logic [COLOR_W-1:0]        night_color;
    logic [COLOR_W-1:0]        sunrise_color;
    logic [COLOR_W-1:0]        day_color;
    logic [COLOR_W-1:0]        sunset_color;
  } cfg_t;

  typedef struct packed {
    logic [BOUND_W-1:0] num;
    logic [BOUND_W-1:0] den;
    logic               zero;
    logic [COLOR_W-1:0] col_a;
    logic [COLOR_W-1:0] col_b;
    phase_t             phase;
  } mid_item_t;

endpackage

>>> rtl/core/dcci_front.sv
// Front end: classifies an hour into a region and prepares the blend operands.
module dcci_front
  import dcci_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [HOUR_W-1:0] hour,
  output mid_item_t         item
);

  function automatic logic signed [CALC_W-1:0] sext(input logic [BOUND_W-1:0] v);
    return $signed({{(CALC_W-BOUND_W){v[BOUND_W-1]}}, v});
  endfunction

  logic signed [CALC_W-1:0] h, sb, se, tb, te, lo, hi, diff, nabs, dlen;
  logic                     in_rise;
  logic [COLOR_W-1:0]       first_col, second_col, mid_col;

  always_comb begin
    h  = $signed({{(CALC_W-HOUR_W){1'b0}}, hour});
    sb = sext(cfg.sunrise_begin);
    se = sext(cfg.sunrise_end);
    tb = sext(cfg.sunset_begin);
    te = sext(cfg.sunset_end);
    in_rise    = (h <= se);
    lo         = in_rise ? sb : tb;
    hi         = in_rise ? se : te;
    mid_col    = in_rise ? cfg.sunrise_color : cfg.sunset_color;
    first_col  = in_rise ? cfg.night_color : cfg.day_color;
    second_col = in_rise ? cfg.day_color : cfg.night_color;
    diff = lo + hi - (h <<< 1);
    nabs = diff[CALC_W-1] ? -diff : diff;
    dlen = hi - lo;
  end

  always_comb begin
    item.num   = '0;
    item.den   = '0;
    item.zero  = 1'b1;
    item.col_a = '0;
    item.col_b = '0;
    item.phase = PHASE_NONE;
    if ((h < sb) || (h > te)) begin
      item.col_a = cfg.night_color;
      item.col_b = cfg.night_color;
      item.phase = PHASE_NIGHT;
    end else if (in_rise || (h >= tb)) begin
      item.num   = nabs[BOUND_W-1:0];
      item.den   = dlen[BOUND_W-1:0];
      item.zero  = (dlen == '0);
      item.col_a = mid_col;
      item.col_b = diff[CALC_W-1] ? second_col : first_col;
      item.phase = in_rise ? PHASE_SUNRISE : PHASE_SUNSET;
    end else if (h < tb) begin
      item.col_a = cfg.day_color;
      item.col_b = cfg.day_color;
      item.phase = PHASE_DAY;
    end
  end

endmodule

>>> rtl/core/dcci_fifo.sv
// Small first-in first-out queue built from registers.
module dcci_fifo
  import dcci_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MID_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CNTW-1:0]  cnt;
  logic             do_push, do_pop;

  assign full    = (cnt == CNTW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> rtl/core/dcci_back.sv
// Back end: pipelined blend factor divider and per channel color blend.
module dcci_back
  import dcci_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mid_item_t          in_item,
  output logic               in_ready,
  output logic               res_valid,
  output logic [COLOR_W-1:0] res_color,
  output phase_t             res_phase,
  input  logic               out_full
);

  localparam int STAGES = QUO_W;
  localparam int CB     = CHANNEL_BITS;
  localparam int PACKW  = CHANNELS * CB;
  localparam int PADW   = PACKW + COLOR_W;
  localparam logic signed [CB+19:0] RND = (CB+20)'(1) <<< (FRAC_W - 1);

  typedef struct packed {
    logic [BOUND_W-1:0] rem;
    logic [BOUND_W-1:0] den;
    logic               zero;
    logic [QUO_W-1:0]   quo;
    logic [COLOR_W-1:0] col_a;
    logic [COLOR_W-1:0] col_b;
    phase_t             phase;
  } div_t;

  logic [STAGES-1:0] vld;
  div_t              st   [STAGES];
  div_t              src  [STAGES];
  div_t              nx   [STAGES];
  logic [BOUND_W:0]  trial[STAGES];
  logic [STAGES-1:0] ge;
  logic              adv;

  assign adv      = !(res_valid && out_full);
  assign in_ready = adv;

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        src[k].rem   = in_item.num;
        src[k].den   = in_item.den;
        src[k].zero  = in_item.zero;
        src[k].quo   = '0;
        src[k].col_a = in_item.col_a;
        src[k].col_b = in_item.col_b;
        src[k].phase = in_item.phase;
        trial[k]     = {1'b0, src[k].rem};
      end else begin
        src[k]   = st[k-1];
        trial[k] = {src[k].rem, 1'b0};
      end
      ge[k]      = (trial[k] >= {1'b0, src[k].den});
      nx[k]      = src[k];
      nx[k].rem  = ge[k] ? BOUND_W'(trial[k] - {1'b0, src[k].den})
                         : trial[k][BOUND_W-1:0];
      nx[k].quo  = {src[k].quo[QUO_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  logic [QUO_W-1:0]        fac;
  logic [PADW-1:0]         pad_a, pad_b, res_wide;
  logic [CB-1:0]           ca   [CHANNELS];
  logic [CB-1:0]           cb   [CHANNELS];
  logic [CB-1:0]           v    [CHANNELS];
  logic signed [CB:0]      delta[CHANNELS];
  logic signed [CB+18:0]   prod [CHANNELS];
  logic signed [CB+19:0]   rnd  [CHANNELS];
  logic signed [CB+19:0]   shr  [CHANNELS];

  always_comb begin
    fac      = st[STAGES-1].zero ? '0 : st[STAGES-1].quo;
    pad_a    = {{PACKW{1'b0}}, st[STAGES-1].col_a};
    pad_b    = {{PACKW{1'b0}}, st[STAGES-1].col_b};
    res_wide = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      ca[c]    = pad_a[c*CB +: CB];
      cb[c]    = pad_b[c*CB +: CB];
      delta[c] = $signed({1'b0, cb[c]}) - $signed({1'b0, ca[c]});
      prod[c]  = delta[c] * $signed({1'b0, fac});
      rnd[c]   = $signed({prod[c][CB+18], prod[c]}) + RND;
      shr[c]   = rnd[c] >>> FRAC_W;
      v[c]     = ca[c] + shr[c][CB-1:0];
      res_wide[c*CB +: CB] = v[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_color <= res_wide[COLOR_W-1:0];
      res_phase <= st[STAGES-1].phase;
    end
  end

endmodule

>>> rtl/core/day_cycle_color_interpolator_top.sv
// Day cycle color interpolator: maps an hour of day to a blended RGBA color.
// Push an hour (unsigned Q5.11) while full is low; each request yields one
// color and phase code, delivered in order and popped while empty is low.
// One request is taken per cycle unless an output stall backs up the queues.
// Each result passes through the front queue, the 17 pipeline stages of the
// restoring divider that forms the Q1.16 blend factor (one quotient bit per
// stage), one blend stage and the output queue.
// Write window bounds and key colors through wr_en/wr_index/wr_data only
// while no request is in flight.
module day_cycle_color_interpolator_top
  import dcci_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter int MID_DEPTH    = MID_DEPTH_DEF,
  parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [HOUR_W-1:0]    hour,
  output logic                 empty,
  input  logic                 pop,
  output logic [COLOR_W-1:0]   color,
  output logic [PHASE_W-1:0]   phase,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [COLOR_W-1:0]   wr_data
);

  localparam int OUT_W = COLOR_W + PHASE_W;

  cfg_t               cfg;
  mid_item_t          front_item, mid_item;
  logic               mid_empty, mid_pop, back_ready;
  logic               res_valid, out_full, out_push;
  logic [COLOR_W-1:0] res_color;
  phase_t             res_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sunrise_begin <= SUNRISE_BEGIN_RST;
      cfg.sunrise_end   <= SUNRISE_END_RST;
      cfg.sunset_begin  <= SUNSET_BEGIN_RST;
      cfg.sunset_end    <= SUNSET_END_RST;
      cfg.night_color   <= '0;
      cfg.sunrise_color <= '0;
      cfg.day_color     <= '0;
      cfg.sunset_color  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_SUNRISE_BEGIN: cfg.sunrise_begin <= wr_data[BOUND_W-1:0];
        REG_SUNRISE_END:   cfg.sunrise_end   <= wr_data[BOUND_W-1:0];
        REG_SUNSET_BEGIN:  cfg.sunset_begin  <= wr_data[BOUND_W-1:0];
        REG_SUNSET_END:    cfg.sunset_end    <= wr_data[BOUND_W-1:0];
        REG_NIGHT_COLOR:   cfg.night_color   <= wr_data;
        REG_SUNRISE_COLOR: cfg.sunrise_color <= wr_data;
        REG_DAY_COLOR:     cfg.day_color     <= wr_data;
        REG_SUNSET_COLOR:  cfg.sunset_color  <= wr_data;
        default: ;
      endcase
    end
  end

  dcci_front u_front (
    .cfg  (cfg),
    .hour (hour),
    .item (front_item)
  );

  dcci_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  assign mid_pop = back_ready && !mid_empty;

  dcci_back #(
    .CHANNELS     (CHANNELS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mid_empty),
    .in_item   (mid_item),
    .in_ready  (back_ready),
    .res_valid (res_valid),
    .res_color (res_color),
    .res_phase (res_phase),
    .out_full  (out_full)
  );

  assign out_push = res_valid && !out_full;

  dcci_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({res_color, res_phase}),
    .full  (out_full),
    .pop   (pop),
    .rdata ({color, phase}),
    .empty (empty)
  );

`ifndef SYNTHESIS
  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_full) |=> res_valid)
    else $error("stalled result dropped before output queue took it");

  a_out_empty_holds: assert property (@(posedge clk) disable iff (rst)
    (empty && !out_push) |=> empty)
    else $error("output queue shows a result that was never pushed");

  a_full_needs_pop: assert property (@(posedge clk) disable iff (rst)
    (full && !mid_pop) |=> full)
    else $error("front queue freed a slot without a pop");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the day cycle color interpolator: directed table, then random hours.
module tb
  import dcci_pkg::*;
();

  localparam int     CH                 = CHANNELS_DEF;
  localparam int     CB                 = CHANNEL_BITS_DEF;
  localparam longint ONE                = 65536;
  localparam int     LATENCY            = 19;
  localparam int     QUIET_LIMIT        = 2000;
  localparam int     HOLD_CYCLES        = 150;
  localparam int     NUM_SETTINGS       = 5;
  localparam int     RANDOM_PER_SETTING = 110;
  localparam int     SCRIPT_LEN         = 32;
  localparam int     PRINT_CAP          = 40;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    phase_t             phase;
  } sky_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_HOUR, ROW_HOUR_EXP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    sky_t        want;
  } script_row_t;

  localparam sky_t NO_CHECK = '{32'h0, PHASE_NONE};

  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd0,          '{32'h0, PHASE_NIGHT}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd10239,      '{32'h0, PHASE_NIGHT}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd10240,      '{32'h0, PHASE_SUNRISE}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd16384,      '{32'h0, PHASE_SUNRISE}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd16385,      '{32'h0, PHASE_DAY}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd36863,      '{32'h0, PHASE_DAY}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd36864,      '{32'h0, PHASE_SUNSET}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd43008,      '{32'h0, PHASE_SUNSET}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd43009,      '{32'h0, PHASE_NIGHT}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd49151,      '{32'h0, PHASE_NIGHT}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd65535,      '{32'h0, PHASE_NIGHT}},
    '{ROW_WRITE,    REG_NIGHT_COLOR,   32'h11223344,   NO_CHECK},
    '{ROW_WRITE,    REG_SUNRISE_COLOR, 32'hFF00FF00,   NO_CHECK},
    '{ROW_WRITE,    REG_DAY_COLOR,     32'hFFFFFFFF,   NO_CHECK},
    '{ROW_WRITE,    REG_SUNSET_COLOR,  32'h00000000,   NO_CHECK},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd10240,      '{32'h11223344, PHASE_SUNRISE}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd13312,      '{32'hFF00FF00, PHASE_SUNRISE}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd16384,      '{32'hFFFFFFFF, PHASE_SUNRISE}},
    '{ROW_HOUR,     REG_SUNRISE_BEGIN, 32'd12000,      NO_CHECK},
    '{ROW_HOUR,     REG_SUNRISE_BEGIN, 32'd15000,      NO_CHECK},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd39936,      '{32'h00000000, PHASE_SUNSET}},
    '{ROW_HOUR,     REG_SUNRISE_BEGIN, 32'd41000,      NO_CHECK},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd43008,      '{32'h11223344, PHASE_SUNSET}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd25000,      '{32'hFFFFFFFF, PHASE_DAY}},
    '{ROW_WRITE,    REG_SUNRISE_BEGIN, 32'd20000,      NO_CHECK},
    '{ROW_WRITE,    REG_SUNRISE_END,   32'd20000,      NO_CHECK},
    '{ROW_WRITE,    REG_SUNSET_BEGIN,  32'hFFFE0000,   NO_CHECK},
    '{ROW_WRITE,    REG_SUNSET_END,    32'h0001FFFF,   NO_CHECK},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd20000,      '{32'hFF00FF00, PHASE_SUNRISE}},
    '{ROW_HOUR_EXP, REG_SUNRISE_BEGIN, 32'd19999,      '{32'h11223344, PHASE_NIGHT}},
    '{ROW_HOUR,     REG_SUNRISE_BEGIN, 32'd30000,      NO_CHECK},
    '{ROW_HOUR,     REG_SUNRISE_BEGIN, 32'd65535,      NO_CHECK}
  };

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 push     = 1'b0;
  logic                 pop      = 1'b0;
  logic [HOUR_W-1:0]    hour     = '0;
  logic                 wr_en    = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [COLOR_W-1:0]   wr_data  = '0;
  wire                  full;
  wire                  empty;
  wire  [COLOR_W-1:0]   color;
  wire  [PHASE_W-1:0]   phase;

  longint             rise_lo, rise_hi, set_lo, set_hi;
  logic [COLOR_W-1:0] night_key, rise_key, day_key, set_key;

  sky_t pending_sky [$];
  sky_t head;
  int   errors        = 0;
  int   checked       = 0;
  int   sent          = 0;
  int   quiet         = 0;
  int   send_idle_pct = 6;
  int   recv_idle_pct = 70;
  int   hold_requests = 0;
  int   holds_done    = 0;
  int   hold_left     = 0;

  day_cycle_color_interpolator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .hour     (hour),
    .empty    (empty),
    .pop      (pop),
    .color    (color),
    .phase    (phase),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [COLOR_W-1:0] mix_channels(logic [COLOR_W-1:0] a,
                                                      logic [COLOR_W-1:0] b, longint f);
    longint     mask, ca, cb, v;
    logic [63:0] acc;
    int          c;
    mask = (longint'(1) << CB) - 1;
    acc  = '0;
    for (c = 0; c < CH; c++) begin
      ca  = longint'(a >> (c * CB)) & mask;
      cb  = longint'(b >> (c * CB)) & mask;
      v   = (ca * (ONE - f) + cb * f + 32768) >>> 16;
      acc = acc | (64'(v & mask) << (c * CB));
    end
    return acc[COLOR_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] window_mix(longint t, longint lo, longint hi,
                                                    logic [COLOR_W-1:0] mid,
                                                    logic [COLOR_W-1:0] first,
                                                    logic [COLOR_W-1:0] second);
    longint d, diff, n, f;
    logic   first_half;
    d          = hi - lo;
    diff       = lo + hi - 2 * t;
    first_half = (diff >= 0);
    n          = first_half ? diff : -diff;
    if (d <= 0) begin
      f = first_half ? 0 : ONE;
    end else begin
      f = (n << 16) / d;
      if (f > ONE) f = ONE;
    end
    return mix_channels(mid, first_half ? first : second, f);
  endfunction

  function automatic sky_t sky_color_at(logic [HOUR_W-1:0] h);
    longint t;
    sky_t   s;
    t       = longint'(h);
    s.color = '0;
    s.phase = PHASE_NONE;
    if (t < rise_lo || t > set_hi) begin
      s.color = mix_channels(night_key, night_key, 0);
      s.phase = PHASE_NIGHT;
    end else if (t >= rise_lo && t <= rise_hi) begin
      s.color = window_mix(t, rise_lo, rise_hi, rise_key, night_key, day_key);
      s.phase = PHASE_SUNRISE;
    end else if (t > rise_hi && t < set_lo) begin
      s.color = mix_channels(day_key, day_key, 0);
      s.phase = PHASE_DAY;
    end else if (t >= set_lo && t <= set_hi) begin
      s.color = window_mix(t, set_lo, set_hi, set_key, day_key, night_key);
      s.phase = PHASE_SUNSET;
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_SUNRISE_BEGIN: rise_lo   = longint'($signed(data[BOUND_W-1:0]));
      REG_SUNRISE_END:   rise_hi   = longint'($signed(data[BOUND_W-1:0]));
      REG_SUNSET_BEGIN:  set_lo    = longint'($signed(data[BOUND_W-1:0]));
      REG_SUNSET_END:    set_hi    = longint'($signed(data[BOUND_W-1:0]));
      REG_NIGHT_COLOR:   night_key = data;
      REG_SUNRISE_COLOR: rise_key  = data;
      REG_DAY_COLOR:     day_key   = data;
      REG_SUNSET_COLOR:  set_key   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_sky.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_hour(logic [HOUR_W-1:0] h, logic given, sky_t want);
    int   gap;
    sky_t e;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    hour <= h;
    e = given ? want : sky_color_at(h);
    do @(posedge clk); while (full);
    pending_sky.push_back(e);
    sent++;
  endtask

  // receiver: random pop, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_sky.size() == 0) begin
        report_mismatch("result with no pending request", color, 32'h0);
      end else begin
        head = pending_sky.pop_front();
        if (color !== head.color) report_mismatch("color", color, head.color);
        if (phase !== head.phase) report_mismatch("phase", 32'(phase), 32'(head.phase));
        checked++;
      end
    end
    if (rst || wr_en || (push && !full) || (pop && !empty)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results pending",
               QUIET_LIMIT, pending_sky.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int                r, k, i, j, pick;
    longint            mark [4];
    longint            t, swap;
    logic [31:0]       hue [4];
    logic [31:0]       junk, data;
    logic [HOUR_W-1:0] h;
    logic              writing;
    rise_lo   = longint'(SUNRISE_BEGIN_RST);
    rise_hi   = longint'(SUNRISE_END_RST);
    set_lo    = longint'(SUNSET_BEGIN_RST);
    set_hi    = longint'(SUNSET_END_RST);
    night_key = '0;
    rise_key  = '0;
    day_key   = '0;
    set_key   = '0;
    writing   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].kind == ROW_WRITE) begin
        if (!writing) drain();
        write_reg(SCRIPT[r].idx, SCRIPT[r].value);
        writing = 1'b1;
      end else begin
        if (writing) wr_en <= 1'b0;
        writing = 1'b0;
        send_hour(SCRIPT[r].value[HOUR_W-1:0], SCRIPT[r].kind == ROW_HOUR_EXP, SCRIPT[r].want);
      end
    end

    for (k = 0; k < NUM_SETTINGS; k++) begin
      for (i = 0; i < 4; i++) begin
        mark[i] = longint'($urandom_range(49151));
        hue[i]  = $urandom();
      end
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3 - i; j++)
          if (mark[j] > mark[j+1]) begin
            swap      = mark[j];
            mark[j]   = mark[j+1];
            mark[j+1] = swap;
          end
      case (k)
        1: begin
          mark = '{-131072, 131071, 131071, 131071};
          hue  = '{32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000};
        end
        3: begin
          for (i = 0; i < 4; i++) mark[i] = longint'($urandom_range(147455)) - 49152;
        end
        4: begin
          mark[1] = mark[0];
          mark[3] = mark[2];
        end
        default: ;
      endcase
      drain();
      send_idle_pct = (k < 2) ? 6 : (k < 4) ? 70 : 0;
      recv_idle_pct = (k < 2) ? 70 : (k < 4) ? 6 : 0;
      for (i = 0; i < 8; i++) begin
        junk = $urandom();
        data = (i < 4) ? {junk[31:BOUND_W], mark[i][BOUND_W-1:0]} : hue[i-4];
        write_reg(reg_idx_t'(i), data);
      end
      wr_en <= 1'b0;
      // stall the output long enough to back up the input
      if (k == NUM_SETTINGS - 1) hold_requests++;
      for (i = 0; i < RANDOM_PER_SETTING; i++) begin
        pick = $urandom_range(3);
        if (pick == 0) begin
          h = HOUR_W'($urandom_range(65535));
        end else if (pick == 3) begin
          t = mark[2'($urandom_range(3))] + longint'($urandom_range(6)) - 3;
          if (t < 0) t = 0;
          if (t > 65535) t = 65535;
          h = t[HOUR_W-1:0];
        end else begin
          h = HOUR_W'($urandom_range(49151));
        end
        send_hour(h, 1'b0, NO_CHECK);
      end
    end

    drain();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Covered %0d hour requests over reset plus %0d register settings;", sent,
             NUM_SETTINGS + 2);
    $display("compared %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dcci_pkg.sv
rtl/core/dcci_front.sv
rtl/core/dcci_fifo.sv
rtl/core/dcci_back.sv
rtl/core/day_cycle_color_interpolator_top.sv
tb/tb.sv
